// File: rtl/form_urlencoded_serializer_top_macros.svh
// Assertion macros shared by the form serializer RTL.
`ifndef FORM_URLENCODED_SERIALIZER_TOP_MACROS_SVH
`define FORM_URLENCODED_SERIALIZER_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define FUS_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("fus assertion failed");

// Check a condition in the cycle after its trigger.
`define FUS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("fus assertion failed");

`endif

// File: rtl/fus_pkg.sv
// Types, character codes and encode helpers for the form serializer.
`default_nettype none
package fus_pkg;

  // Item kind codes
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Character codes
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  localparam int unsigned MAX_CHARS = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // Encoded group: up to three characters, first in chars[0]
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_CHARS-1:0][7:0] chars;
  } enc_group_t;

  // Uppercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    hex_char = (nib < 4'd10) ? (CH_ZERO + n8) : (CH_UC_A + n8 - 8'd10);
  endfunction

  // Unreserved characters go out unchanged
  function automatic logic passes_through(input logic [7:0] b);
    passes_through = (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z) ||
                     (b >= CH_ZERO && b <= CH_NINE) || (b == CH_DASH) ||
                     (b == CH_UNDER) || (b == CH_DOT) || (b == CH_TILDE);
  endfunction

endpackage
`default_nettype wire

// File: rtl/fus_skid.sv
// Two-entry input skid buffer with a registered stall.
`default_nettype none
module fus_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fus_pkg::in_item_t in_data,
  output logic                   head_vld,
  output fus_pkg::in_item_t      head_item,
  input  wire logic              head_pop
);
  import fus_pkg::*;

  logic     main_vld_r, main_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  in_item_t main_r, main_nxt;
  in_item_t skid_r, skid_nxt;
  logic     acc;

  assign in_stall  = skid_vld_r;
  assign acc       = in_valid && !skid_vld_r;
  assign head_vld  = main_vld_r;
  assign head_item = main_r;

  // Refill the head from the skid entry first, then from the input
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (head_pop) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = in_data;
        main_vld_nxt = acc;
      end
    end else if (acc) begin
      if (!main_vld_r) begin
        main_nxt     = in_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = in_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/fus_encoder.sv
// Encodes one item into a group of up to three characters.
`default_nettype none
module fus_encoder (
  input  wire fus_pkg::in_item_t item,
  input  wire logic              first_pending,
  output fus_pkg::enc_group_t    grp,
  output logic                   first_pending_nxt
);
  import fus_pkg::*;

  always_comb begin
    grp.cnt           = 2'd0;
    grp.chars         = '0;
    first_pending_nxt = first_pending;
    unique case (item.kind)
      KIND_NAME: begin
        // Separator only between fields
        if (first_pending) begin
          first_pending_nxt = 1'b0;
        end else begin
          grp.cnt      = 2'd1;
          grp.chars[0] = CH_AMP;
        end
      end
      KIND_VALUE: begin
        grp.cnt      = 2'd1;
        grp.chars[0] = CH_EQ;
      end
      KIND_DATA: begin
        if (item.data_byte == CH_SPACE) begin
          grp.cnt      = 2'd1;
          grp.chars[0] = CH_PLUS;
        end else if (passes_through(item.data_byte)) begin
          grp.cnt      = 2'd1;
          grp.chars[0] = item.data_byte;
        end else begin
          // Escape as percent plus two hex digits
          grp.cnt      = 2'd3;
          grp.chars[0] = CH_PCT;
          grp.chars[1] = hex_char(item.data_byte[7:4]);
          grp.chars[2] = hex_char(item.data_byte[3:0]);
        end
      end
      KIND_END: begin
        first_pending_nxt = 1'b1;
      end
      default: begin
        first_pending_nxt = first_pending;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/fus_emit.sv
// Result register: holds one encoded group and sends it one character per beat.
`default_nettype none
module fus_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ld,
  input  wire fus_pkg::enc_group_t grp,
  output logic                     ld_ok,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fus_pkg::out_item_t       out_data
);
  import fus_pkg::*;

  `include "form_urlencoded_serializer_top_macros.svh"

  logic [1:0]                cnt_r, cnt_nxt;
  logic [MAX_CHARS-1:0][7:0] ch_r, ch_nxt;
  logic                      beat;

  assign out_valid         = (cnt_r != 2'd0);
  assign beat              = out_valid && !out_stall;
  assign ld_ok             = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && beat);
  assign out_data.out_char = ch_r[0];
  assign out_data.last     = (cnt_r == 2'd1);

  // Load a new group or shift the held one forward
  always_comb begin
    cnt_nxt = cnt_r;
    ch_nxt  = ch_r;
    if (ld) begin
      cnt_nxt = grp.cnt;
      ch_nxt  = grp.chars;
    end else if (beat) begin
      cnt_nxt   = cnt_r - 2'd1;
      ch_nxt[0] = ch_r[1];
      ch_nxt[1] = ch_r[2];
      ch_nxt[2] = ch_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
  end

  // A full group always opens with the percent sign
  `FUS_ASSERT_SAME(a_pct_head, cnt_r == 2'd3, ch_r[0] == CH_PCT)
  // A taken beat inside a group steps the count down by one
  `FUS_ASSERT_NEXT(a_cnt_step, (cnt_r > 2'd1) && !out_stall, cnt_r == $past(cnt_r) - 2'd1)
  // Never overwrite characters that are still owed
  `FUS_ASSERT_SAME(a_no_clobber, ld, (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall))

endmodule
`default_nettype wire

// File: rtl/form_urlencoded_serializer_top.sv
// Form-urlencoded serializer: markers and data bytes in, encoded characters out.
//
// Input channel (in_valid / in_stall / in_data): one beat per item; kind picks
// a field-name start, a value start, a data byte or the end of a form.
// Output channel (out_valid / out_stall / out_data): one beat per character;
// last marks the final character caused by an item.
// An item's first character is offered once it has passed the skid head register
// and been loaded into the output register. Throughput: one character per cycle
// at the output register while out_stall is low; a new group loads as the last
// character of the one before is taken, and an escaped byte's group is held until
// its three characters are out. in_stall comes from a register: a two-entry skid
// buffer takes the beat in flight on an output stall, then raises in_stall.
// While out_stall is high the offered character and its last flag hold.
// Reset (rst_n low at a clock edge) empties both buffers and the output
// register and rearms the first-field flag, so the next name start emits no '&'.
`default_nettype none
module form_urlencoded_serializer_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fus_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fus_pkg::out_item_t     out_data
);
  import fus_pkg::*;

  logic       head_vld;
  in_item_t   head_item;
  logic       head_pop;
  enc_group_t grp;
  logic       first_r, first_nxt, first_enc;
  logic       ld_ok;
  logic       ld;

  fus_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .head_vld  (head_vld),
    .head_item (head_item),
    .head_pop  (head_pop)
  );

  fus_encoder u_enc (
    .item              (head_item),
    .first_pending     (first_r),
    .grp               (grp),
    .first_pending_nxt (first_enc)
  );

  // Items without characters retire at once; others wait for the result slot
  assign head_pop  = head_vld && ((grp.cnt == 2'd0) || ld_ok);
  assign ld        = head_pop && (grp.cnt != 2'd0);
  assign first_nxt = head_pop ? first_enc : first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else begin
      first_r <= first_nxt;
    end
  end

  fus_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .grp       (grp),
    .ld_ok     (ld_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: verif/form_encode_checker.sv
// Checker for the form serializer: predicts encoded characters and compares them.
`timescale 1ns / 100ps
`default_nettype none
module form_encode_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire fus_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire fus_pkg::out_item_t out_data,
  output int                      mismatches,
  output int                      chars_waiting,
  output int                      chars_checked
);
  import fus_pkg::*;

  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789ABCDEF";

  // Characters still owed by the block, oldest first
  out_item_t expected_chars[$];
  // Set while no field name has been started in the current form
  logic      awaiting_first_name;
  int        fail_count;
  int        char_count;

  initial begin
    fail_count    = 0;
    char_count    = 0;
    awaiting_first_name = 1'b1;
  end

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HEX_DIGITS[8*(15 - int'(nib)) +: 8];
  endfunction

  function automatic bit plain_char(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE], [CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z],
                     CH_DASH, CH_UNDER, CH_DOT, CH_TILDE};
  endfunction

  // Append one owed character at the tail
  task automatic owe_char(input logic [7:0] c, input logic fin);
    out_item_t ent;
    ent.out_char = c;
    ent.last     = fin;
    expected_chars.insert(expected_chars.size(), ent);
  endtask

  // Queue the characters that one input beat must produce
  task automatic predict_item(input in_item_t item);
    logic [7:0] b;
    b = item.data_byte;
    case (item.kind)
      KIND_NAME: begin
        if (awaiting_first_name) begin
          awaiting_first_name = 1'b0;
        end else begin
          owe_char(CH_AMP, 1'b1);
        end
      end
      KIND_VALUE: begin
        owe_char(CH_EQ, 1'b1);
      end
      KIND_DATA: begin
        if (b == CH_SPACE) begin
          owe_char(CH_PLUS, 1'b1);
        end else if (plain_char(b)) begin
          owe_char(b, 1'b1);
        end else begin
          owe_char(CH_PCT, 1'b0);
          owe_char(hex_digit(b[7:4]), 1'b0);
          owe_char(hex_digit(b[3:0]), 1'b1);
        end
      end
      default: begin
        awaiting_first_name = 1'b1;
      end
    endcase
  endtask

  // Watch both channels; predict on input beats, compare on output beats
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_chars.delete();
      awaiting_first_name = 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
      end
      if (out_valid && !out_stall) begin
        char_count++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b",
                                    out_data.out_char, out_data.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch($sformatf("out_char %h, expected %h",
                                      out_data.out_char, want.out_char));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("last %b on char %h, expected %b",
                                      out_data.last, out_data.out_char, want.last));
          end
        end
      end
    end
    mismatches    <= fail_count;
    chars_waiting <= expected_chars.size();
    chars_checked <= char_count;
  end

endmodule
`default_nettype wire

// File: verif/form_urlencoded_serializer_top_tb.sv
// Testbench top for the form serializer: stimulus, idle phases and verdict.
`timescale 1ns / 100ps
`default_nettype none
module form_urlencoded_serializer_top_tb;
  import fus_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int forms_sent     = 0;
  int mismatches;
  int chars_waiting;
  int chars_checked;

  form_urlencoded_serializer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  form_encode_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .chars_waiting (chars_waiting),
    .chars_checked (chars_checked)
  );

  always #2 clk = ~clk;

  // Stall the output side at random; the rate only changes on a falling edge
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one beat, with an optional idle gap first; hold it until accepted
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, data_byte: b};
    // in_stall is registered, so it is stable by the falling edge
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, then switch sender and receiver rates between edges
  task automatic set_phase(input int idle_pct, input int stall_pct);
    in_valid <= 1'b0;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk);
  endtask

  // Hold the input until every owed character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_waiting != 0);
  endtask

  // Byte for a name or value, weighted toward text with some escapes
  function automatic logic [7:0] pick_text_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return CH_LC_A + 8'($urandom_range(25));
    if (sel < 30) return CH_UC_A + 8'($urandom_range(25));
    if (sel < 38) return CH_ZERO + 8'($urandom_range(9));
    if (sel < 50) return CH_SPACE;
    if (sel < 60) begin
      case ($urandom_range(3))
        0:       return CH_DASH;
        1:       return CH_UNDER;
        2:       return CH_DOT;
        default: return CH_TILDE;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_text(input int len);
    repeat (len) send_item(KIND_DATA, pick_text_byte());
  endtask

  // One well-formed form: name/value pairs closed by an end marker
  task automatic send_form();
    int fields;
    fields = $urandom_range(1, 4);
    repeat (fields) begin
      send_item(KIND_NAME, 8'($urandom_range(255)));
      send_text($urandom_range(0, 5));
      send_item(KIND_VALUE, 8'($urandom_range(255)));
      send_text($urandom_range(0, 6));
    end
    send_item(KIND_END, 8'($urandom_range(255)));
    forms_sent++;
  endtask

  // Random markers and bytes in any order
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int count, input bit mid_pause);
    int target;
    bit paused;
    target = items_sent + count;
    paused = 1'b0;
    while (items_sent < target) begin
      if ($urandom_range(99) < 10) send_noise();
      else send_form();
      if (mid_pause && !paused && items_sent >= target - count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Directed items: markers in odd places, field extremes, class edges
  task automatic run_directed();
    send_item(KIND_NAME,  8'hFF);    // first name: nothing out
    send_item(KIND_DATA,  CH_LC_A);
    send_item(KIND_VALUE, 8'h5A);
    send_item(KIND_DATA,  CH_SPACE);
    send_item(KIND_DATA,  8'h00);
    send_item(KIND_DATA,  8'hFF);
    send_item(KIND_NAME,  8'h00);    // later name: ampersand
    send_item(KIND_DATA,  CH_TILDE);
    send_item(KIND_DATA,  CH_DASH);
    send_item(KIND_DATA,  CH_UNDER);
    send_item(KIND_DATA,  CH_DOT);
    send_item(KIND_VALUE, 8'hC3);
    send_item(KIND_DATA,  8'h2F);    // just below the digits
    send_item(KIND_DATA,  CH_NINE);
    send_item(KIND_DATA,  8'h3A);    // just above the digits
    send_item(KIND_DATA,  8'h40);
    send_item(KIND_DATA,  CH_UC_Z);
    send_item(KIND_DATA,  8'h5B);
    send_item(KIND_DATA,  8'h60);
    send_item(KIND_DATA,  CH_LC_Z);
    send_item(KIND_DATA,  8'h7B);
    send_item(KIND_END,   8'hFF);
    send_item(KIND_END,   8'h00);    // empty form
    send_item(KIND_VALUE, 8'hFF);    // value with no name before it
    send_item(KIND_DATA,  CH_PCT);   // data outside any field
    send_item(KIND_NAME,  8'hAA);    // first name of a new form
  endtask

  // Reset, then directed items and four idle/stall phases of random forms
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    set_phase(0, 0);
    run_random(110, 1'b0);
    set_phase(45, 0);
    run_random(120, 1'b1);
    set_phase(0, 45);
    run_random(120, 1'b0);
    set_phase(14, 14);
    run_random(120, 1'b0);
    wait_drained();
    repeat (12) @(posedge clk);
    $display("Sent %0d items (%0d complete forms) and checked %0d characters",
             items_sent, forms_sent, chars_checked);
    $display("under no idling, sender gaps, receiver stalls and both mixed");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Bound the run in case a handshake never completes
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
